>>> rtl/core/plat_pkg.sv
// shared types and constants of the priority lock arbiter with silence timeout
// no dependencies; used by every module under rtl/core
`default_nettype none

package plat_pkg;

  // number of command sources in use (2 to 8); the source field is always 3 bits
  localparam int NUM_SOURCES = 8;

  localparam int SRC_W       = 3;
  localparam int MAX_SOURCES = 1 << SRC_W;
  localparam int PRIO_W      = 8;
  localparam int TMO_W       = 16;
  localparam int PAYLOAD_W   = 64;
  localparam int CFG_W       = 64;
  localparam int CFG_IDX_W   = 2;

  localparam logic [SRC_W:0]   SRC_LIMIT   = (SRC_W + 1)'(NUM_SOURCES);
  localparam logic [TMO_W-1:0] SILENCE_MAX = '1;

  typedef enum logic {
    OP_MSG  = 1'b0,
    OP_TICK = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    RSN_KEPT     = 3'd0,
    RSN_FIRST    = 3'd1,
    RSN_PRIORITY = 3'd2,
    RSN_TIMEOUT  = 3'd3,
    RSN_REFUSED  = 3'd4,
    RSN_TICK     = 3'd5
  } reason_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PRIO   = 2'd0,
    CFG_TMO_LO = 2'd1,
    CFG_TMO_HI = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    op_e                  op;
    logic [SRC_W-1:0]     source;
    logic [PAYLOAD_W-1:0] payload;
  } in_beat_t;

  typedef struct packed {
    logic                 forward;
    logic [SRC_W-1:0]     holder;
    logic                 holder_valid;
    reason_e              reason;
    logic [PAYLOAD_W-1:0] payload_out;
  } out_beat_t;

  // per-source settings, unpacked from the three config registers
  typedef struct packed {
    logic [MAX_SOURCES-1:0][PRIO_W-1:0] prio;
    logic [MAX_SOURCES-1:0][TMO_W-1:0]  timeout;
  } cfg_t;

endpackage

`default_nettype wire

>>> rtl/core/plat_cfg_regs.sv
// configuration registers: priority table and the two timeout words
// depends on plat_pkg
`default_nettype none

module plat_cfg_regs (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [plat_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [plat_pkg::CFG_W-1:0]        cfg_wdata_i,
  output plat_pkg::cfg_t                         cfg_o
);

  logic [plat_pkg::CFG_W-1:0] prio_q;
  logic [plat_pkg::CFG_W-1:0] tmo_lo_q;
  logic [plat_pkg::CFG_W-1:0] tmo_hi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prio_q   <= '0;
      tmo_lo_q <= '0;
      tmo_hi_q <= '0;
    end else if (cfg_we_i) begin
      case (plat_pkg::cfg_reg_e'(cfg_idx_i))
        plat_pkg::CFG_PRIO:   prio_q   <= cfg_wdata_i;
        plat_pkg::CFG_TMO_LO: tmo_lo_q <= cfg_wdata_i;
        plat_pkg::CFG_TMO_HI: tmo_hi_q <= cfg_wdata_i;
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // source k priority in byte k, timeouts 0..3 in the low word, 4..7 in the high
  assign cfg_o.prio    = prio_q;
  assign cfg_o.timeout = {tmo_hi_q, tmo_lo_q};

endmodule

`default_nettype wire

>>> rtl/core/plat_lock_core.sv
// lock state and per-beat arbitration decision
// depends on plat_pkg
`default_nettype none

module plat_lock_core (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire plat_pkg::cfg_t       cfg_i,
  input  wire plat_pkg::in_beat_t   beat_i,
  input  wire logic                 fire_i,
  output plat_pkg::out_beat_t       result_o
);

  logic                             taken_q,   taken_d;
  logic [plat_pkg::SRC_W-1:0]       owner_q,   owner_d;
  logic [plat_pkg::TMO_W-1:0]       silence_q, silence_d;
  logic                             fwd;
  plat_pkg::reason_e                rsn;
  logic [plat_pkg::PRIO_W-1:0]      holder_prio;
  logic [plat_pkg::PRIO_W-1:0]      sender_prio;
  logic [plat_pkg::TMO_W-1:0]       holder_tmo;
  logic                             src_bad;

  assign holder_prio = cfg_i.prio[owner_q];
  assign sender_prio = cfg_i.prio[beat_i.source];
  assign holder_tmo  = cfg_i.timeout[owner_q];
  assign src_bad     = {1'b0, beat_i.source} >= plat_pkg::SRC_LIMIT;

  always_comb begin
    taken_d   = taken_q;
    owner_d   = owner_q;
    silence_d = silence_q;
    fwd       = 1'b0;
    rsn       = plat_pkg::RSN_REFUSED;
    if (beat_i.op == plat_pkg::OP_TICK) begin
      if (silence_q != plat_pkg::SILENCE_MAX) begin
        silence_d = silence_q + 1'b1;
      end
      rsn = plat_pkg::RSN_TICK;
    end else if (src_bad) begin
      rsn = plat_pkg::RSN_REFUSED;
    end else if (!taken_q) begin
      rsn = plat_pkg::RSN_FIRST;
      fwd = 1'b1;
    end else if (owner_q == beat_i.source) begin
      rsn = plat_pkg::RSN_KEPT;
      fwd = 1'b1;
    end else if (sender_prio > holder_prio) begin
      rsn = plat_pkg::RSN_PRIORITY;
      fwd = 1'b1;
    end else if (silence_q >= holder_tmo) begin
      rsn = plat_pkg::RSN_TIMEOUT;
      fwd = 1'b1;
    end
    if (fwd) begin
      taken_d   = 1'b1;
      owner_d   = beat_i.source;
      silence_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      taken_q   <= 1'b0;
      owner_q   <= '0;
      silence_q <= '0;
    end else if (fire_i) begin
      taken_q   <= taken_d;
      owner_q   <= owner_d;
      silence_q <= silence_d;
    end
  end

  assign result_o.forward      = fwd;
  assign result_o.holder       = owner_d;
  assign result_o.holder_valid = taken_d;
  assign result_o.reason       = rsn;
  assign result_o.payload_out  = fwd ? beat_i.payload : '0;

`ifndef SYNTHESIS
  a_fwd_clears_silence: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && fwd |=> silence_q == '0 && taken_q)
    else $error("forwarded beat did not restart silence count");

  a_lock_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    taken_q |=> taken_q)
    else $error("lock released after being taken");

  a_no_holder_owner_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !taken_q |-> owner_q == '0)
    else $error("owner set while no holder");

  a_refuse_keeps_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && !fwd |=> owner_q == $past(owner_q) && taken_q == $past(taken_q))
    else $error("owner changed on a refused beat or tick");
`endif

endmodule

`default_nettype wire

>>> rtl/core/priority_lock_arbiter_timeout_unit.sv
// top level of the priority lock arbiter with per-source silence timeout
// depends on plat_pkg, plat_cfg_regs, plat_lock_core
//
//   channel  direction  handshake                  beat
//   in       sink       in_valid_i / in_ready_o    plat_pkg::in_beat_t
//   out      source     out_valid_o / out_ready_i  plat_pkg::out_beat_t
//   cfg      sink       cfg_we_i (no wait)         cfg_idx_i, cfg_wdata_i
//
// one beat per cycle sustained while out is not stalled; a taken beat goes to out
// via the input register, then decision and lock update into the result register
// the lock state advances when a beat moves from the input to the result register
// async active-low reset clears the lock, config and both valid flags
// while out stalls, the input register still fills, then in_ready_o drops
`default_nettype none

module priority_lock_arbiter_timeout_unit (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // config write port
  input  wire logic                           cfg_we_i,
  input  wire logic [plat_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [plat_pkg::CFG_W-1:0]     cfg_wdata_i,
  // input beats
  input  wire logic                           in_valid_i,
  output      logic                           in_ready_o,
  input  wire plat_pkg::in_beat_t             in_beat_i,
  // result beats
  output      logic                           out_valid_o,
  input  wire logic                           out_ready_i,
  output plat_pkg::out_beat_t                 out_beat_o
);

  plat_pkg::cfg_t      cfg;
  plat_pkg::in_beat_t  in_q;
  logic                in_valid_q;
  plat_pkg::out_beat_t out_q;
  plat_pkg::out_beat_t result;
  logic                out_valid_q;
  logic                out_take;
  logic                fire;

  plat_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // result register can load when empty or being drained this cycle
  assign out_take   = !out_valid_q || out_ready_i;
  // a held beat is decided and moves on, updating the lock
  assign fire       = in_valid_q && out_take;
  // input register frees up as its beat moves to the result register
  assign in_ready_o = !in_valid_q || out_take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_beat_i;
    end
  end

  plat_lock_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .beat_i   (in_q),
    .fire_i   (fire),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_take) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

endmodule

`default_nettype wire

>>> tb/priority_lock_arbiter_timeout_unit_tb.sv
// self-checking testbench of priority_lock_arbiter_timeout_unit: a directed table, then random
// beats with random idling, each result checked against a pinned value or the lock predictor
// depends on plat_pkg and the rtl of priority_lock_arbiter_timeout_unit
`timescale 1ns / 1ps

module priority_lock_arbiter_timeout_unit_tb;
  import plat_pkg::*;

  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int RANDOM_PHASES   = 4;
  localparam int BEATS_PER_PHASE = 150;
  localparam int HOLD_CYCLES     = 60;
  // result passes the input and result registers after its beat is taken; leave margin
  localparam int TAIL_CYCLES     = 4;

  // ---------------------------------------------------------------------------
  // dut signals
  // ---------------------------------------------------------------------------
  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_wdata_i;
  logic                 in_valid_i;
  logic                 in_ready_o;
  in_beat_t             in_beat_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  out_beat_t            out_beat_o;

  priority_lock_arbiter_timeout_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_beat_i   (in_beat_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_beat_o  (out_beat_o)
  );

  // ---------------------------------------------------------------------------
  // directed table: config rows write one register once the block is idle,
  // beat rows carry a hand-typed result where it is obvious (pinned)
  // ---------------------------------------------------------------------------
  typedef enum logic {
    ROW_BEAT = 1'b0,
    ROW_CFG  = 1'b1
  } row_kind_e;

  typedef struct packed {
    row_kind_e            kind;
    op_e                  op;
    logic [SRC_W-1:0]     src;
    cfg_reg_e             cfg_sel;
    logic [PAYLOAD_W-1:0] data;
    logic                 pinned;
    logic                 exp_fwd;
    logic [SRC_W-1:0]     exp_holder;
    logic                 exp_hv;
    reason_e              exp_reason;
  } plan_row_t;

  localparam int PLAN_ROWS = 25;

  // priorities: src7 ff, src6 01, src5 02, src4 03, src3 05, src2 05, src1 06, src0 00
  // timeouts:   src7 1, src6 0, src5 4, src4 5, src3 ffff, src2 3, src1 0, src0 2
  plan_row_t plan [PLAN_ROWS] = '{
    // all config at reset value zero
    '{ROW_BEAT, OP_TICK, 3'd0, CFG_PRIO, 64'h0, 1'b1, 1'b0, 3'd0, 1'b0, RSN_TICK},
    '{ROW_BEAT, OP_MSG, 3'd0, CFG_PRIO, 64'hFFFF_FFFF_FFFF_FFFF,
      1'b1, 1'b1, 3'd0, 1'b1, RSN_FIRST},
    // zero timeout: any sender displaces the holder at once
    '{ROW_BEAT, OP_MSG, 3'd7, CFG_PRIO, 64'h8000_0000_0000_0001,
      1'b1, 1'b1, 3'd7, 1'b1, RSN_TIMEOUT},
    '{ROW_BEAT, OP_MSG, 3'd7, CFG_PRIO, 64'h0, 1'b1, 1'b1, 3'd7, 1'b1, RSN_KEPT},
    '{ROW_CFG, OP_MSG, 3'd0, CFG_PRIO, 64'hFF01_0203_0505_0600,
      1'b0, 1'b0, 3'd0, 1'b0, RSN_KEPT},
    '{ROW_CFG, OP_MSG, 3'd0, CFG_TMO_LO, 64'hFFFF_0003_0000_0002,
      1'b0, 1'b0, 3'd0, 1'b0, RSN_KEPT},
    '{ROW_CFG, OP_MSG, 3'd0, CFG_TMO_HI, 64'h0001_0000_0004_0005,
      1'b0, 1'b0, 3'd0, 1'b0, RSN_KEPT},
    // lower priority, holder not silent long enough
    '{ROW_BEAT, OP_MSG, 3'd1, CFG_PRIO, 64'h0123_4567_89AB_CDEF,
      1'b1, 1'b0, 3'd7, 1'b1, RSN_REFUSED},
    '{ROW_BEAT, OP_TICK, 3'd5, CFG_PRIO, 64'h0, 1'b1, 1'b0, 3'd7, 1'b1, RSN_TICK},
    // silence reached the holder's timeout
    '{ROW_BEAT, OP_MSG, 3'd1, CFG_PRIO, 64'hFEDC_BA98_7654_3210,
      1'b1, 1'b1, 3'd1, 1'b1, RSN_TIMEOUT},
    '{ROW_BEAT, OP_MSG, 3'd2, CFG_PRIO, 64'h5555_5555_5555_5555,
      1'b0, 1'b0, 3'd0, 1'b0, RSN_KEPT},
    // equal priority does not displace before the holder's timeout
    '{ROW_BEAT, OP_MSG, 3'd3, CFG_PRIO, 64'hAAAA_AAAA_AAAA_AAAA,
      1'b1, 1'b0, 3'd2, 1'b1, RSN_REFUSED},
    '{ROW_BEAT, OP_TICK, 3'd0, CFG_PRIO, 64'h0, 1'b0, 1'b0, 3'd0, 1'b0, RSN_KEPT},
    '{ROW_BEAT, OP_TICK, 3'd7, CFG_PRIO, 64'h0, 1'b0, 1'b0, 3'd0, 1'b0, RSN_KEPT},
    '{ROW_BEAT, OP_MSG, 3'd3, CFG_PRIO, 64'h0000_0000_FFFF_FFFF,
      1'b0, 1'b0, 3'd0, 1'b0, RSN_KEPT},
    '{ROW_BEAT, OP_TICK, 3'd0, CFG_PRIO, 64'h0, 1'b0, 1'b0, 3'd0, 1'b0, RSN_KEPT},
    '{ROW_BEAT, OP_MSG, 3'd3, CFG_PRIO, 64'hFFFF_FFFF_0000_0000,
      1'b0, 1'b0, 3'd0, 1'b0, RSN_KEPT},
    '{ROW_BEAT, OP_MSG, 3'd0, CFG_PRIO, 64'h1, 1'b0, 1'b0, 3'd0, 1'b0, RSN_KEPT},
    '{ROW_BEAT, OP_MSG, 3'd4, CFG_PRIO, 64'h2, 1'b0, 1'b0, 3'd0, 1'b0, RSN_KEPT},
    // strictly higher priority wins
    '{ROW_BEAT, OP_MSG, 3'd1, CFG_PRIO, 64'h3C3C_3C3C_3C3C_3C3C,
      1'b1, 1'b1, 3'd1, 1'b1, RSN_PRIORITY},
    '{ROW_BEAT, OP_MSG, 3'd6, CFG_PRIO, 64'hC3C3_C3C3_C3C3_C3C3,
      1'b0, 1'b0, 3'd0, 1'b0, RSN_KEPT},
    '{ROW_BEAT, OP_MSG, 3'd7, CFG_PRIO, 64'h7FFF_FFFF_FFFF_FFFE,
      1'b1, 1'b1, 3'd7, 1'b1, RSN_PRIORITY},
    '{ROW_BEAT, OP_MSG, 3'd7, CFG_PRIO, 64'h0F0F_0F0F_0F0F_0F0F,
      1'b0, 1'b0, 3'd0, 1'b0, RSN_KEPT},
    '{ROW_BEAT, OP_MSG, 3'd5, CFG_PRIO, 64'hF0F0_F0F0_F0F0_F0F0,
      1'b0, 1'b0, 3'd0, 1'b0, RSN_KEPT},
    '{ROW_BEAT, OP_TICK, 3'd2, CFG_PRIO, 64'hFFFF_FFFF_FFFF_FFFF,
      1'b0, 1'b0, 3'd0, 1'b0, RSN_KEPT}
  };

  // ---------------------------------------------------------------------------
  // bench state
  // ---------------------------------------------------------------------------
  out_beat_t expected_q [$];
  int        beats_sent   = 0;
  int        results_seen = 0;
  int        fail_count   = 0;
  int        cycle_count  = 0;
  bit        no_idle         = 1'b0;
  bit        long_stall_req  = 1'b0;

  // hand-typed result that travels with the beat on offer
  logic      typed_valid;
  out_beat_t typed_result;

  // arbiter shadow: lock state and the three config words
  logic             lock_held    = 1'b0;
  logic [SRC_W-1:0] lock_owner_q = '0;
  logic [TMO_W-1:0] silence_q    = '0;
  logic [CFG_W-1:0] prio_word    = '0;
  logic [CFG_W-1:0] tmo_lo_word  = '0;
  logic [CFG_W-1:0] tmo_hi_word  = '0;

  // ---------------------------------------------------------------------------
  // clock and cycle watchdog
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // arbitration predictor: advances the shadow lock state by one beat
  // ---------------------------------------------------------------------------
  function automatic out_beat_t arbitrate(in_beat_t b);
    out_beat_t         res;
    logic [PRIO_W-1:0] prio_src;
    logic [PRIO_W-1:0] prio_own;
    logic [TMO_W-1:0]  own_timeout;
    prio_src    = prio_word[PRIO_W*b.source +: PRIO_W];
    prio_own    = prio_word[PRIO_W*lock_owner_q +: PRIO_W];
    own_timeout = lock_owner_q[2] ? tmo_hi_word[TMO_W*lock_owner_q[1:0] +: TMO_W]
                                  : tmo_lo_word[TMO_W*lock_owner_q[1:0] +: TMO_W];
    res = '0;
    if (b.op == OP_TICK) begin
      // silence ages even with no holder, saturating at the top
      if (silence_q != SILENCE_MAX) silence_q++;
      res.reason = RSN_TICK;
    end else if (int'(b.source) >= NUM_SOURCES) begin
      res.reason = RSN_REFUSED;
    end else if (!lock_held) begin
      res.reason  = RSN_FIRST;
      res.forward = 1'b1;
    end else if (lock_owner_q == b.source) begin
      res.reason  = RSN_KEPT;
      res.forward = 1'b1;
    end else if (prio_src > prio_own) begin
      res.reason  = RSN_PRIORITY;
      res.forward = 1'b1;
    end else if (silence_q >= own_timeout) begin
      res.reason  = RSN_TIMEOUT;
      res.forward = 1'b1;
    end else begin
      res.reason = RSN_REFUSED;
    end
    if (res.forward) begin
      lock_held       = 1'b1;
      lock_owner_q    = b.source;
      silence_q       = '0;
      res.payload_out = b.payload;
    end
    res.holder       = lock_owner_q;
    res.holder_valid = lock_held;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // monitor: checks result beats, records taken beats and register writes,
  // all on the values that held just before the edge
  // ---------------------------------------------------------------------------
  task automatic compare_field(string name, logic [PAYLOAD_W-1:0] want,
                               logic [PAYLOAD_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk_i) begin
    out_beat_t want;
    out_beat_t predicted;
    if (rst_ni) begin
      // result side first, so a result is never matched to a beat taken at the same edge
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (expected_q.size() == 0) begin
          $error("result beat with nothing expected: %p", out_beat_o);
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          compare_field("forward", PAYLOAD_W'(want.forward),
                        PAYLOAD_W'(out_beat_o.forward));
          compare_field("holder", PAYLOAD_W'(want.holder),
                        PAYLOAD_W'(out_beat_o.holder));
          compare_field("holder_valid", PAYLOAD_W'(want.holder_valid),
                        PAYLOAD_W'(out_beat_o.holder_valid));
          compare_field("reason", PAYLOAD_W'(want.reason),
                        PAYLOAD_W'(out_beat_o.reason));
          compare_field("payload_out", want.payload_out, out_beat_o.payload_out);
        end
      end
      if (in_valid_i && in_ready_o) begin
        // state advances even when a typed result stands in for the prediction
        predicted = arbitrate(in_beat_i);
        expected_q.push_back(typed_valid ? typed_result : predicted);
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_PRIO:   prio_word   <= cfg_wdata_i;
          CFG_TMO_LO: tmo_lo_word <= cfg_wdata_i;
          CFG_TMO_HI: tmo_hi_word <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: random stalls, one long hold-off on request, none in burst mode
  // ---------------------------------------------------------------------------
  initial begin
    int stall_left;
    int pick;
    stall_left = 0;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (long_stall_req) begin
        // block fills up and must push back on the sender
        long_stall_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else if (no_idle) begin
        out_ready_i <= 1'b1;
      end else if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          out_ready_i <= 1'b1;
        end else begin
          stall_left = (pick < 94) ? $urandom_range(0, 2) : $urandom_range(9, 24);
          out_ready_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sender helpers
  // ---------------------------------------------------------------------------
  function automatic int pick_gap();
    int pick;
    if (no_idle) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 70) return 0;
    if (pick < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [PAYLOAD_W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // eight priority bytes in 0..maxv
  function automatic logic [CFG_W-1:0] rand_prio_word(int maxv);
    logic [CFG_W-1:0] w;
    for (int k = 0; k < 8; k++) w[PRIO_W*k +: PRIO_W] = PRIO_W'($urandom_range(0, maxv));
    return w;
  endfunction

  // four timeout halfwords in 0..maxv
  function automatic logic [CFG_W-1:0] rand_tmo_word(int maxv);
    logic [CFG_W-1:0] w;
    for (int k = 0; k < 4; k++) w[TMO_W*k +: TMO_W] = TMO_W'($urandom_range(0, maxv));
    return w;
  endfunction

  // offer one beat after a random gap and hold it until taken
  task automatic send_beat(op_e op, logic [SRC_W-1:0] src, logic [PAYLOAD_W-1:0] data,
                           logic pin, out_beat_t pinned);
    int       gap;
    in_beat_t b;
    gap       = pick_gap();
    b.op      = op;
    b.source  = src;
    b.payload = data;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    in_beat_i    <= b;
    typed_valid  <= pin;
    typed_result <= pinned;
    do @(posedge clk_i); while (!in_ready_o);
    beats_sent++;
  endtask

  // stop offering and wait until every result beat is in, plus pipeline margin
  task automatic drain();
    in_valid_i <= 1'b0;
    while (results_seen < beats_sent) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e sel, logic [CFG_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= sel;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_all(logic [CFG_W-1:0] prio, logic [CFG_W-1:0] tmo_lo,
                           logic [CFG_W-1:0] tmo_hi);
    drain();
    write_reg(CFG_PRIO, prio);
    write_reg(CFG_TMO_LO, tmo_lo);
    write_reg(CFG_TMO_HI, tmo_hi);
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    out_beat_t        typed;
    op_e              op;
    logic [SRC_W-1:0] src;
    logic [SRC_W-1:0] last_src;
    logic [PAYLOAD_W-1:0] data;
    int               pick;

    rst_ni       <= 1'b0;
    cfg_we_i     <= 1'b0;
    cfg_idx_i    <= CFG_PRIO;
    cfg_wdata_i  <= '0;
    in_valid_i   <= 1'b0;
    in_beat_i    <= '0;
    typed_valid  <= 1'b0;
    typed_result <= '0;
    last_src = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        drain();
        write_reg(plan[i].cfg_sel, plan[i].data);
      end else begin
        typed.forward      = plan[i].exp_fwd;
        typed.holder       = plan[i].exp_holder;
        typed.holder_valid = plan[i].exp_hv;
        typed.reason       = plan[i].exp_reason;
        typed.payload_out  = plan[i].exp_fwd ? plan[i].data : '0;
        send_beat(plan[i].op, plan[i].src, plan[i].data, plan[i].pinned, typed);
      end
    end

    // random phases, each under its own config
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0:       write_all(rand_prio_word(255), rand_tmo_word(6), rand_tmo_word(6));
        1:       write_all('0, '0, '0);
        2:       write_all(rand_prio_word(2), rand_tmo_word(12), rand_tmo_word(12));
        default: write_all(rand_prio_word(255), '1, rand_tmo_word(3));
      endcase
      for (int n = 0; n < BEATS_PER_PHASE; n++) begin
        // long receiver hold-off while beats keep coming
        if (ph == 0 && n == 40) long_stall_req = 1'b1;
        // sender pause until the pipe is empty
        if (ph == 0 && n == 100) drain();
        // a stretch with no idling on either side
        if (ph == 2) no_idle = (n >= 50 && n < 80);
        pick = $urandom_range(0, 99);
        op   = (pick < 30) ? OP_TICK : OP_MSG;
        // re-send from the last source often, so held locks get kept and aged
        pick = $urandom_range(0, 99);
        src  = (pick < 35) ? last_src : 3'($urandom_range(0, 7));
        if (op == OP_MSG) last_src = src;
        pick = $urandom_range(0, 99);
        if (pick < 8) data = '1;
        else if (pick < 16) data = '0;
        else data = rand_word();
        send_beat(op, src, data, 1'b0, '0);
      end
    end

    drain();
    if (expected_q.size() != 0) begin
      $error("%0d result beats never arrived", expected_q.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/plat_pkg.sv
rtl/core/plat_cfg_regs.sv
rtl/core/plat_lock_core.sv
rtl/core/priority_lock_arbiter_timeout_unit.sv
tb/priority_lock_arbiter_timeout_unit_tb.sv
